### hdl/scle_pkg.sv
// ----------------------------------------------------------------------------
// scle_pkg
// Shared types, codes and the set-1 key table for the scancode line editor.
// ----------------------------------------------------------------------------
package scle_pkg;

   localparam int LINE_CAPACITY_DEF = 64;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ON    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_MODE = 2'd2;

   // character and scancode constants
   localparam logic [7:0] SC_RELEASE  = 8'h80;
   localparam logic [6:0] SC_KEY_MASK = 7'h7F;
   localparam logic [7:0] SC_LSHIFT   = 8'h2A;
   localparam logic [7:0] SC_RSHIFT   = 8'h36;
   localparam logic [7:0] SC_TBL_SIZE = 8'd58;
   localparam logic [7:0] CH_NUL      = 8'd0;
   localparam logic [7:0] CH_BS       = 8'd8;
   localparam logic [7:0] CH_LF       = 8'd10;
   localparam logic [7:0] CH_CR       = 8'd13;
   localparam logic [7:0] CH_SPACE    = 8'd32;
   localparam logic [7:0] CH_TILDE    = 8'd126;
   localparam logic [7:0] CH_DEL      = 8'd127;
   localparam logic [6:0] CH_LOWER_A  = 7'h61;
   localparam logic [6:0] CH_LOWER_Z  = 7'h7A;
   localparam logic [6:0] CH_CASE_OFS = 7'd32;

   // what one keyboard code asks the line editor to do
   localparam logic [2:0] KEY_NONE      = 3'd0;
   localparam logic [2:0] KEY_SHIFT_ON  = 3'd1;
   localparam logic [2:0] KEY_SHIFT_OFF = 3'd2;
   localparam logic [2:0] KEY_PRINT     = 3'd3;
   localparam logic [2:0] KEY_BKSP      = 3'd4;
   localparam logic [2:0] KEY_ENTER     = 3'd5;

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] ch;
   } scle_key_type;

   // PS/2 set 1 make code to character, zero where the key has no character
   function automatic logic [6:0] set1_char(input logic [5:0] idx);
      logic [6:0] c;
      case (idx)
         6'd1:  c = 7'h1B;
         6'd2:  c = 7'h31;
         6'd3:  c = 7'h32;
         6'd4:  c = 7'h33;
         6'd5:  c = 7'h34;
         6'd6:  c = 7'h35;
         6'd7:  c = 7'h36;
         6'd8:  c = 7'h37;
         6'd9:  c = 7'h38;
         6'd10: c = 7'h39;
         6'd11: c = 7'h30;
         6'd12: c = 7'h2D;
         6'd13: c = 7'h3D;
         6'd14: c = 7'h08;
         6'd15: c = 7'h09;
         6'd16: c = 7'h71;
         6'd17: c = 7'h77;
         6'd18: c = 7'h65;
         6'd19: c = 7'h72;
         6'd20: c = 7'h74;
         6'd21: c = 7'h79;
         6'd22: c = 7'h75;
         6'd23: c = 7'h69;
         6'd24: c = 7'h6F;
         6'd25: c = 7'h70;
         6'd26: c = 7'h5B;
         6'd27: c = 7'h5D;
         6'd28: c = 7'h0A;
         6'd30: c = 7'h61;
         6'd31: c = 7'h73;
         6'd32: c = 7'h64;
         6'd33: c = 7'h66;
         6'd34: c = 7'h67;
         6'd35: c = 7'h68;
         6'd36: c = 7'h6A;
         6'd37: c = 7'h6B;
         6'd38: c = 7'h6C;
         6'd39: c = 7'h3B;
         6'd40: c = 7'h27;
         6'd41: c = 7'h60;
         6'd43: c = 7'h5C;
         6'd44: c = 7'h7A;
         6'd45: c = 7'h78;
         6'd46: c = 7'h63;
         6'd47: c = 7'h76;
         6'd48: c = 7'h62;
         6'd49: c = 7'h6E;
         6'd50: c = 7'h6D;
         6'd51: c = 7'h2C;
         6'd52: c = 7'h2E;
         6'd53: c = 7'h2F;
         6'd55: c = 7'h2A;
         6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

### hdl/scle_decode.sv
// ----------------------------------------------------------------------------
// scle_decode
// Turn one keyboard code into a line-editor action and its character.
// ----------------------------------------------------------------------------
module scle_decode (
   input  logic [7:0]             code,
   input  logic                   input_mode,
   input  logic                   shift_held,
   output scle_pkg::scle_key_type key
);
   import scle_pkg::*;

   logic [6:0] tbl_char;
   logic [6:0] rel_key;
   logic [7:0] ch;
   logic       is_shift;
   logic       is_char;

   assign rel_key  = code[6:0] & SC_KEY_MASK;
   assign is_shift = (code == SC_LSHIFT) || (code == SC_RSHIFT);

   always_comb begin
      tbl_char = set1_char(code[5:0]);
      if (shift_held && (tbl_char >= CH_LOWER_A) && (tbl_char <= CH_LOWER_Z)) begin
         tbl_char = 7'(tbl_char - CH_CASE_OFS);
      end
   end

   always_comb begin
      ch      = CH_NUL;
      is_char = 1'b0;
      key     = '{kind: KEY_NONE, ch: 7'd0};
      if (input_mode) begin
         is_char = 1'b1;
         if (code == CH_CR) begin
            ch = CH_LF;
         end else if (code == CH_DEL) begin
            ch = CH_BS;
         end else begin
            ch = code;
         end
      end else if ((code & SC_RELEASE) != 8'd0) begin
         // release: only the shift keys matter
         if ((rel_key == SC_LSHIFT[6:0]) || (rel_key == SC_RSHIFT[6:0])) begin
            key.kind = KEY_SHIFT_OFF;
         end
      end else if (is_shift) begin
         key.kind = KEY_SHIFT_ON;
      end else if (code < SC_TBL_SIZE) begin
         is_char = 1'b1;
         ch      = {1'b0, tbl_char};
      end

      if (is_char) begin
         key.ch = ch[6:0];
         if (ch == CH_NUL) begin
            key.kind = KEY_NONE;
         end else if ((ch == CH_LF) || (ch == CH_CR)) begin
            key.kind = KEY_ENTER;
         end else if ((ch == CH_BS) || (ch == CH_DEL)) begin
            key.kind = KEY_BKSP;
         end else if ((ch >= CH_SPACE) && (ch <= CH_TILDE)) begin
            key.kind = KEY_PRINT;
         end
      end
   end

endmodule

### hdl/scancode_line_editor_top.sv
// ----------------------------------------------------------------------------
// scancode_line_editor_top
// Keyboard code to edited command line: set-1 or ASCII decode, line store, echo and
// streaming of the finished line.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_code
//   rsp      out        rsp_valid/rsp_stall  rsp_echo_*, rsp_line_*, rsp_prompt_request,
//                                            rsp_last
//   csr      in         csr_write            csr_index, csr_data
//
// An item passes through accept and decode when it gives no result or one
// result. Enter on a stored line streams it out character by character: each
// character is read from the line memory in READ, then moved into the output
// register in EMIT. Reset is synchronous and clears the control state, the
// line length and the shift flag; the line memory is not cleared. A stall on
// rsp holds the block in decode or emit until the output register frees up.
// ----------------------------------------------------------------------------
module scancode_line_editor_top #(
   parameter int LINE_CAPACITY = scle_pkg::LINE_CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_code,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_echo_valid,
   output logic [6:0]                     rsp_echo_char,
   output logic                           rsp_line_valid,
   output logic [6:0]                     rsp_line_char,
   output logic                           rsp_line_done,
   output logic                           rsp_prompt_request,
   output logic                           rsp_last,
   // configuration
   input  logic                           csr_write,
   input  logic [scle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                           csr_data
);
   import scle_pkg::*;

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DECODE = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   // configuration registers
   logic enable_ff, echo_on_ff, input_mode_ff;

   // control and line state
   logic [1:0]       state_ff, state_in;
   logic [7:0]       code_ff, code_in;
   logic             shift_ff, shift_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;

   // line memory, one write port and one registered read port
   logic [6:0]       line_mem [LINE_CAPACITY];
   logic [6:0]       rd_data_ff;
   logic             wr_en;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic       echo_valid_ff, echo_valid_in;
   logic [6:0] echo_char_ff, echo_char_in;
   logic       line_valid_ff, line_valid_in;
   logic [6:0] line_char_ff, line_char_in;
   logic       line_done_ff, line_done_in;
   logic       prompt_ff, prompt_in;
   logic       last_ff, last_in;

   scle_key_type key;
   logic         out_free;
   logic         rd_last;

   scle_decode u_decode (
      .code       (code_ff),
      .input_mode (input_mode_ff),
      .shift_held (shift_ff),
      .key        (key)
   );

   // output register is free when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rd_last   = (rd_idx_ff == LEN_W'(len_ff - 1'b1));
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      shift_in      = shift_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      wr_en         = 1'b0;
      out_valid_in  = out_valid_ff && rsp_stall;
      echo_valid_in = echo_valid_ff;
      echo_char_in  = echo_char_ff;
      line_valid_in = line_valid_ff;
      line_char_in  = line_char_ff;
      line_done_in  = line_done_ff;
      prompt_in     = prompt_ff;
      last_in       = last_ff;

      case (state_ff)
         ST_IDLE: begin
            // take the next item even while a result still waits
            if (req_valid) begin
               code_in  = req_code;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!enable_ff) begin
               state_in = ST_IDLE;
            end else begin
               case (key.kind)
                  KEY_SHIFT_ON: begin
                     shift_in = 1'b1;
                     state_in = ST_IDLE;
                  end
                  KEY_SHIFT_OFF: begin
                     shift_in = 1'b0;
                     state_in = ST_IDLE;
                  end
                  KEY_PRINT: begin
                     // wait for the output slot so the store happens once
                     if (out_free) begin
                        state_in = ST_IDLE;
                        if (len_ff < LEN_MAX) begin
                           wr_en  = 1'b1;
                           len_in = LEN_W'(len_ff + 1'b1);
                           if (echo_on_ff) begin
                              out_valid_in  = 1'b1;
                              echo_valid_in = 1'b1;
                              echo_char_in  = key.ch;
                              line_valid_in = 1'b0;
                              line_char_in  = 7'd0;
                              line_done_in  = 1'b0;
                              prompt_in     = 1'b0;
                              last_in       = 1'b1;
                           end
                        end
                     end
                  end
                  KEY_BKSP: begin
                     if (len_ff == '0) begin
                        state_in = ST_IDLE;
                     end else if (out_free) begin
                        state_in      = ST_IDLE;
                        len_in        = LEN_W'(len_ff - 1'b1);
                        out_valid_in  = 1'b1;
                        echo_valid_in = 1'b1;
                        echo_char_in  = CH_BS[6:0];
                        line_valid_in = 1'b0;
                        line_char_in  = 7'd0;
                        line_done_in  = 1'b0;
                        prompt_in     = 1'b0;
                        last_in       = 1'b1;
                     end
                  end
                  KEY_ENTER: begin
                     if (len_ff != '0) begin
                        rd_idx_in = '0;
                        state_in  = ST_READ;
                     end else if (out_free) begin
                        // empty line: newline echo plus prompt request
                        state_in      = ST_IDLE;
                        out_valid_in  = 1'b1;
                        echo_valid_in = 1'b1;
                        echo_char_in  = CH_LF[6:0];
                        line_valid_in = 1'b0;
                        line_char_in  = 7'd0;
                        line_done_in  = 1'b0;
                        prompt_in     = 1'b1;
                        last_in       = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // first character carries the newline echo, last one the done mark
            if (out_free) begin
               out_valid_in  = 1'b1;
               echo_valid_in = (rd_idx_ff == '0);
               echo_char_in  = (rd_idx_ff == '0) ? CH_LF[6:0] : 7'd0;
               line_valid_in = 1'b1;
               line_char_in  = rd_data_ff;
               line_done_in  = rd_last;
               prompt_in     = 1'b0;
               last_in       = rd_last;
               if (rd_last) begin
                  len_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = LEN_W'(rd_idx_ff + 1'b1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         shift_ff      <= 1'b0;
         len_ff        <= '0;
         out_valid_ff  <= 1'b0;
         enable_ff     <= 1'b1;
         echo_on_ff    <= 1'b1;
         input_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_ENABLE:     enable_ff     <= csr_data;
               CSR_ECHO_ON:    echo_on_ff    <= csr_data;
               CSR_INPUT_MODE: input_mode_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      rd_idx_ff     <= rd_idx_in;
      echo_valid_ff <= echo_valid_in;
      echo_char_ff  <= echo_char_in;
      line_valid_ff <= line_valid_in;
      line_char_ff  <= line_char_in;
      line_done_ff  <= line_done_in;
      prompt_ff     <= prompt_in;
      last_ff       <= last_in;
   end

   // line memory: writes only in decode, reads only while streaming
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[len_ff] <= key.ch;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= line_mem[rd_idx_ff];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_echo_valid     = echo_valid_ff;
   assign rsp_echo_char      = echo_char_ff;
   assign rsp_line_valid     = line_valid_ff;
   assign rsp_line_char      = line_char_ff;
   assign rsp_line_done      = line_done_ff;
   assign rsp_prompt_request = prompt_ff;
   assign rsp_last           = last_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && line_done_ff) |-> last_ff)
      else $error("line done without last");

   a_prompt_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && prompt_ff) |->
         (echo_valid_ff && (echo_char_ff == CH_LF[6:0]) && !line_valid_ff && last_ff))
      else $error("prompt request with wrong payload");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted item not decoded");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("line length beyond capacity");

   a_read_in_line: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_EMIT)) |-> (rd_idx_ff < len_ff))
      else $error("stream index past line end");

endmodule

### bench/scancode_line_editor_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_line_editor_top_test
// Self-checking bench: keyboard codes in, echoes and finished lines out.
// A clocked driver feeds codes from a queue. Each accepted code goes through
// a behavioral line editor that queues the results it implies. A clocked
// monitor compares every delivered result with the oldest one due. Both
// sides idle at random; register writes happen only with the block drained.
// ----------------------------------------------------------------------------
module scancode_line_editor_top_test;
   import scle_pkg::*;

   // set-1 make codes used by name in the stimulus and the key table
   localparam logic [7:0] SC_ESC_KEY   = 8'h01;
   localparam logic [7:0] SC_BKSP_KEY  = 8'h0E;
   localparam logic [7:0] SC_TAB_KEY   = 8'h0F;
   localparam logic [7:0] SC_ENTER_KEY = 8'h1C;
   localparam logic [7:0] SC_CTRL_KEY  = 8'h1D;
   localparam logic [7:0] SC_A_KEY     = 8'h1E;
   localparam logic [7:0] SC_GRAVE_KEY = 8'h29;
   localparam logic [7:0] SC_Z_KEY     = 8'h2C;
   localparam logic [7:0] SC_ALT_KEY   = 8'h38;
   localparam logic [7:0] SC_SPACE_KEY = 8'h39;
   localparam logic [7:0] SC_CAPS_KEY  = 8'h3A;
   localparam logic [7:0] SC_ONE_KEY   = 8'h02;
   localparam logic [7:0] CODE_MAX     = 8'hFF;

   localparam logic [7:0] CH_TAB      = 8'd9;
   localparam logic [7:0] CH_ESC      = 8'd27;
   localparam logic [7:0] CH_GRAVE    = 8'h60;
   localparam logic [7:0] CH_UNIT_SEP = 8'h1F;
   localparam logic [7:0] CH_HI_LF    = 8'h8A;
   localparam logic [7:0] KEY_HOLE    = 8'h23;

   // key table, one character per make code; holes are keys without a character
   localparam int KEY_COUNT = 58;
   localparam logic [8*KEY_COUNT-1:0] KEY_ROW =
      "##1234567890-=##qwertyuiop[]##asdfghjkl;'##\\zxcvbnm,./#*# ";

   localparam int LINE_MAX    = LINE_CAPACITY_DEF - 1;
   localparam int DRAIN_WAIT  = 8;    // a code without results clears through accept and decode
   localparam int TAIL_WAIT   = 140;  // longer than a full line stream
   localparam int IDLE_PCT    = 9;

   typedef struct packed {
      logic       echo_v;
      logic [6:0] echo_c;
      logic       line_v;
      logic [6:0] line_c;
      logic       done;
      logic       prompt;
      logic       last;
   } editor_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_code = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_echo_valid;
   logic [6:0] rsp_echo_char;
   logic       rsp_line_valid;
   logic [6:0] rsp_line_char;
   logic       rsp_line_done;
   logic       rsp_prompt_request;
   logic       rsp_last;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ENABLE;
   logic                 csr_data = 1'b0;

   // codes waiting to be sent, results due from the block
   logic [7:0]     key_codes[$];
   editor_out_type due_results[$];
   int             sent = 0;
   int             mismatches = 0;

   // shadow of the editor: registers, shift flag and the stored line
   logic       cfg_enable = 1'b1;
   logic       cfg_echo = 1'b1;
   logic       cfg_ascii = 1'b0;
   logic       shift_on = 1'b0;
   int         line_len = 0;
   logic [6:0] line_buf[0:63];

   // free-running 11-bit count; the top eighth of its range is idle-free
   logic [10:0] cyc = 11'd0;
   wire         quiet = &cyc[10:8];

   scancode_line_editor_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_code           (req_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_char      (rsp_echo_char),
      .rsp_line_valid     (rsp_line_valid),
      .rsp_line_char      (rsp_line_char),
      .rsp_line_done      (rsp_line_done),
      .rsp_prompt_request (rsp_prompt_request),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cyc <= cyc + 11'd1;
   end

   // character for a make code below the table size
   function automatic logic [7:0] set1_key(input logic [7:0] code);
      logic [7:0] ch;
      case (code)
         SC_ESC_KEY:   ch = CH_ESC;
         SC_BKSP_KEY:  ch = CH_BS;
         SC_TAB_KEY:   ch = CH_TAB;
         SC_ENTER_KEY: ch = CH_LF;
         SC_GRAVE_KEY: ch = CH_GRAVE;
         default: begin
            ch = KEY_ROW[8*(KEY_COUNT-1-code) +: 8];
            if (ch == KEY_HOLE)
               ch = CH_NUL;
         end
      endcase
      return ch;
   endfunction

   function automatic editor_out_type out_item(input logic ev, input logic [6:0] ec,
                                               input logic lv, input logic [6:0] lc,
                                               input logic dn, input logic pr,
                                               input logic lst);
      editor_out_type o;
      o.echo_v = ev;
      o.echo_c = ec;
      o.line_v = lv;
      o.line_c = lc;
      o.done   = dn;
      o.prompt = pr;
      o.last   = lst;
      return o;
   endfunction

   // Decode one accepted code, update the shadow line and queue its results.
   task automatic apply_key(input logic [7:0] code);
      logic [7:0] c;
      int         k;
      c = CH_NUL;
      if (!cfg_enable || code == CH_NUL)
         return;
      if (cfg_ascii) begin
         c = code;
         if (c == CH_CR)
            c = CH_LF;
         if (c == CH_DEL)
            c = CH_BS;
      end else begin
         // key release: only a shift release matters
         if (code[7]) begin
            if (code[6:0] == SC_LSHIFT[6:0] || code[6:0] == SC_RSHIFT[6:0])
               shift_on = 1'b0;
            return;
         end
         if (code == SC_LSHIFT || code == SC_RSHIFT) begin
            shift_on = 1'b1;
            return;
         end
         if (code < SC_TBL_SIZE) begin
            c = set1_key(code);
            if (shift_on && c >= "a" && c <= "z")
               c = c - {1'b0, CH_CASE_OFS};
         end
      end
      if (c == CH_NUL)
         return;

      if (c == CH_LF) begin
         // empty line asks for the prompt; otherwise stream the line out
         if (line_len == 0) begin
            due_results.push_back(out_item(1'b1, CH_LF[6:0], 1'b0, 7'd0, 1'b0, 1'b1, 1'b1));
         end else begin
            for (k = 0; k < line_len; k++)
               due_results.push_back(out_item(k == 0, (k == 0) ? CH_LF[6:0] : 7'd0, 1'b1,
                                              line_buf[k], k == line_len - 1, 1'b0,
                                              k == line_len - 1));
            line_len = 0;
         end
      end else if (c == CH_BS) begin
         // backspace echoes regardless of echo_on; drop it on an empty line
         if (line_len > 0) begin
            line_len--;
            due_results.push_back(out_item(1'b1, CH_BS[6:0], 1'b0, 7'd0, 1'b0, 1'b0, 1'b1));
         end
      end else if (c >= CH_SPACE && c <= CH_TILDE && line_len < LINE_MAX) begin
         line_buf[line_len] = c[6:0];
         line_len++;
         if (cfg_echo)
            due_results.push_back(out_item(1'b1, c[6:0], 1'b0, 7'd0, 1'b0, 1'b0, 1'b1));
      end
   endtask

   // Driver: predict at acceptance, then advance or hold the payload.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            apply_key(req_code);
         if (!req_valid || !req_stall) begin
            if (key_codes.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_code  <= key_codes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_result();
      editor_out_type want;
      if (due_results.size() == 0) begin
         flag_mismatch("result with none due", int'(rsp_echo_char), 0);
         return;
      end
      want = due_results.pop_front();
      if (rsp_echo_valid != want.echo_v)
         flag_mismatch("echo_valid", int'(rsp_echo_valid), int'(want.echo_v));
      if (rsp_echo_char != want.echo_c)
         flag_mismatch("echo_char", int'(rsp_echo_char), int'(want.echo_c));
      if (rsp_line_valid != want.line_v)
         flag_mismatch("line_valid", int'(rsp_line_valid), int'(want.line_v));
      if (rsp_line_char != want.line_c)
         flag_mismatch("line_char", int'(rsp_line_char), int'(want.line_c));
      if (rsp_line_done != want.done)
         flag_mismatch("line_done", int'(rsp_line_done), int'(want.done));
      if (rsp_prompt_request != want.prompt)
         flag_mismatch("prompt_request", int'(rsp_prompt_request), int'(want.prompt));
      if (rsp_last != want.last)
         flag_mismatch("last", int'(rsp_last), int'(want.last));
   endtask

   // Monitor: check each delivered result, then pick the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic send(input logic [7:0] code);
      key_codes.push_back(code);
      sent++;
   endtask

   // Hold until every code is taken and every result is in, then let a
   // trailing no-result code clear the pipeline.
   task automatic settle();
      do
         @(posedge clock);
      while (key_codes.size() != 0 || req_valid || due_results.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ENABLE:  cfg_enable = val;
         CSR_ECHO_ON: cfg_echo = val;
         default:     cfg_ascii = val;
      endcase
   endtask

   function automatic logic [7:0] pick_print_key();
      logic [7:0] k;
      do
         k = 8'($urandom_range(SC_ONE_KEY, SC_TBL_SIZE - 1));
      while (set1_key(k) < CH_SPACE || set1_key(k) > CH_TILDE);
      return k;
   endfunction

   // One typed line: mostly printable keys, some with shift held, some
   // releases, backspaces and stray codes, closed by enter.
   task automatic queue_line(input int n);
      int         k;
      int         r;
      logic [7:0] key;
      logic [7:0] sh;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send(8'($urandom_range(0, CODE_MAX)));
         end else if (r < 14) begin
            send(cfg_ascii ? (r[0] ? CH_DEL : CH_BS) : SC_BKSP_KEY);
         end else if (cfg_ascii) begin
            send(8'($urandom_range(CH_SPACE, CH_TILDE)));
         end else if (r < 28) begin
            key = pick_print_key();
            sh  = r[0] ? SC_LSHIFT : SC_RSHIFT;
            send(sh);
            send(key);
            // now and then leave shift held into the next keys
            if (r < 25)
               send(sh | SC_RELEASE);
         end else begin
            key = pick_print_key();
            send(key);
            if (r[1])
               send(key | SC_RELEASE);
         end
      end
      if (cfg_ascii)
         send($urandom_range(0, 1) ? CH_CR : CH_LF);
      else
         send(SC_ENTER_KEY);
   endtask

   // Overfill the line so the tail is dropped, then stream the longest line.
   task automatic queue_full_line();
      int k;
      for (k = 0; k < LINE_MAX + 3; k++)
         send(cfg_ascii ? 8'($urandom_range(CH_SPACE, CH_TILDE)) : pick_print_key());
      send(cfg_ascii ? CH_CR : SC_ENTER_KEY);
   endtask

   // Random lines until the count reaches the target, pausing now and then
   // until the block has delivered everything.
   task automatic run_lines(input int target);
      while (sent < target) begin
         queue_line($urandom_range(0, 12));
         if ($urandom_range(0, 3) == 0)
            settle();
      end
      settle();
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // scancode mode, reset settings: null code, plain and shifted letters,
      // shifted digit, releases, backspace, tab, escape, keys without a
      // character, codes past the table, enter on a line and on an empty line
      send(CH_NUL);
      send(SC_A_KEY);
      send(SC_LSHIFT);
      send(SC_A_KEY);
      send(SC_ONE_KEY);
      send(SC_LSHIFT | SC_RELEASE);
      send(SC_SPACE_KEY);
      send(SC_BKSP_KEY);
      send(SC_TAB_KEY);
      send(SC_ESC_KEY);
      send(SC_CAPS_KEY);
      send(CODE_MAX);
      send(SC_CTRL_KEY);
      send(SC_ALT_KEY);
      send(SC_RSHIFT);
      send(SC_Z_KEY);
      send(SC_RSHIFT | SC_RELEASE);
      send(SC_ENTER_KEY);
      send(SC_ENTER_KEY);
      send(SC_BKSP_KEY);
      settle();

      // ASCII mode: edges of the printable range, DEL, high codes, CR and LF,
      // backspace on an empty line, a control character
      write_reg(CSR_INPUT_MODE, 1'b1);
      send(CH_TILDE);
      send(CH_SPACE);
      send(CH_DEL);
      send(SC_RELEASE);
      send(CODE_MAX);
      send(CH_HI_LF);
      send(CH_UNIT_SEP);
      send(CH_CR);
      send(CH_LF);
      send(CH_BS);
      settle();

      // scancode, echo on: random lines and one overfilled line
      write_reg(CSR_INPUT_MODE, 1'b0);
      run_lines(sent + 20);
      queue_full_line();
      settle();

      // scancode, echo off: characters are stored silently
      write_reg(CSR_ECHO_ON, 1'b0);
      run_lines(sent + 15);

      // block disabled: every code is dropped and nothing changes
      write_reg(CSR_ENABLE, 1'b0);
      for (k = 0; k < 12; k++)
         key_codes.push_back(k[0] ? SC_ENTER_KEY : 8'($urandom_range(0, CODE_MAX)));
      settle();
      write_reg(CSR_ENABLE, 1'b1);

      // ASCII, echo off, then echo on
      write_reg(CSR_INPUT_MODE, 1'b1);
      run_lines(sent + 15);
      write_reg(CSR_ECHO_ON, 1'b1);
      run_lines(sent + 15);

      // back to scancode for a last stretch
      write_reg(CSR_INPUT_MODE, 1'b0);
      run_lines(sent + 10);

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("** scancode_line_editor_top: PASSED **");
      end else begin
         $display("** scancode_line_editor_top: FAILED **");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("** scancode_line_editor_top: FAILED **");
      $finish;
   end

endmodule
